// File: hdl/hrc_pkg.sv
// Shared result codes, record type codes and the result word layout.
package hrc_pkg;

   localparam int PAGE_BYTES_DEFAULT = 128;

   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_GOOD   = 2'd1;
   localparam logic [1:0] KIND_BAD    = 2'd2;
   localparam logic [1:0] KIND_EOF    = 2'd3;

   localparam logic [7:0] REC_TYPE_DATA = 8'h00;
   localparam logic [7:0] REC_TYPE_EOF  = 8'h01;

   localparam logic [7:0] PAD_BYTE = 8'hFF;

   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [15:0] flash_word;
      logic [6:0]  byte_offset;
      logic [7:0]  page_number;
      logic        page_done;
   } result_type;

endpackage

// File: hdl/hrc_core.sv
// Record field sequencer, checksum, word packing and page tracking for one byte.
module hrc_core #(
   parameter int PAGE_BYTES = hrc_pkg::PAGE_BYTES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         rec_byte,
   output hrc_pkg::result_type res
);

   localparam int OFFS_W = $clog2(PAGE_BYTES);
   localparam int EXT_W  = (OFFS_W > 7) ? OFFS_W : 7;
   localparam logic [OFFS_W:0] PAGE_LIMIT = (OFFS_W + 1)'(PAGE_BYTES);
   localparam logic [OFFS_W:0] WORD_BYTES = (OFFS_W + 1)'(2);

   typedef enum logic [2:0] {
      POS_LENGTH  = 3'd0,
      POS_ADDR_HI = 3'd1,
      POS_ADDR_LO = 3'd2,
      POS_TYPE    = 3'd3,
      POS_DATA    = 3'd4,
      POS_CHECK   = 3'd5
   } field_pos_type;

   field_pos_type      pos_ff, pos_in;
   logic [7:0]         length_ff, length_in;
   logic [7:0]         left_ff, left_in;
   logic [7:0]         rec_kind_ff, rec_kind_in;
   logic [7:0]         sum_ff, sum_in;
   logic [7:0]         low_ff, low_in;
   logic               have_low_ff, have_low_in;
   logic [OFFS_W-1:0]  offset_ff, offset_in;
   logic [7:0]         page_ff, page_in;
   logic               ended_ff, ended_in;

   logic [OFFS_W:0]    offset_next;
   logic               page_full;
   logic [EXT_W-1:0]   offset_ext;
   logic [7:0]         left_dec;
   logic [7:0]         expect_sum;
   logic               emit;
   logic [15:0]        emit_word;

   assign offset_next = {1'b0, offset_ff} + WORD_BYTES;
   assign page_full   = (offset_next >= PAGE_LIMIT);
   assign offset_ext  = EXT_W'(offset_ff);
   assign left_dec    = left_ff - 8'd1;
   assign expect_sum  = 8'd0 - sum_ff;

   always_comb begin
      pos_in      = pos_ff;
      length_in   = length_ff;
      left_in     = left_ff;
      rec_kind_in = rec_kind_ff;
      sum_in      = sum_ff;
      low_in      = low_ff;
      have_low_in = have_low_ff;
      offset_in   = offset_ff;
      page_in     = page_ff;
      ended_in    = ended_ff;
      emit        = 1'b0;
      emit_word   = 16'd0;

      res             = '0;
      res.byte_offset = offset_ext[6:0];
      res.page_number = page_ff;

      if (!ended_ff) begin
         case (pos_ff)
            POS_ADDR_HI: begin
               sum_in = sum_ff + rec_byte;
               pos_in = POS_ADDR_LO;
            end
            POS_ADDR_LO: begin
               sum_in = sum_ff + rec_byte;
               pos_in = POS_TYPE;
            end
            POS_TYPE: begin
               rec_kind_in = rec_byte;
               sum_in      = sum_ff + rec_byte;
               left_in     = length_ff;
               have_low_in = 1'b0;
               pos_in      = (length_ff != 8'd0) ? POS_DATA : POS_CHECK;
            end
            POS_DATA: begin
               sum_in  = sum_ff + rec_byte;
               left_in = left_dec;
               if (rec_kind_ff == hrc_pkg::REC_TYPE_DATA) begin
                  if (have_low_ff) begin
                     have_low_in = 1'b0;
                     emit        = 1'b1;
                     emit_word   = {rec_byte, low_ff};
                  end else if (left_dec == 8'd0) begin
                     // odd trailing byte: pad the high half
                     emit      = 1'b1;
                     emit_word = {hrc_pkg::PAD_BYTE, rec_byte};
                  end else begin
                     low_in      = rec_byte;
                     have_low_in = 1'b1;
                  end
               end
               if (left_dec == 8'd0) begin
                  pos_in = POS_CHECK;
               end
            end
            POS_CHECK: begin
               res.valid = 1'b1;
               if (rec_kind_ff == hrc_pkg::REC_TYPE_EOF) begin
                  ended_in      = 1'b1;
                  res.kind      = hrc_pkg::KIND_EOF;
                  res.page_done = 1'b1;
               end else begin
                  res.kind = (expect_sum == rec_byte) ? hrc_pkg::KIND_GOOD
                                                      : hrc_pkg::KIND_BAD;
               end
               pos_in      = POS_LENGTH;
               sum_in      = 8'd0;
               have_low_in = 1'b0;
            end
            default: begin
               length_in   = rec_byte;
               sum_in      = rec_byte;
               have_low_in = 1'b0;
               pos_in      = POS_ADDR_HI;
            end
         endcase
      end

      if (emit) begin
         res.valid      = 1'b1;
         res.kind       = hrc_pkg::KIND_DATA;
         res.flash_word = emit_word;
         res.page_done  = page_full;
         // wrap to the next page when this word fills it
         if (page_full) begin
            offset_in = '0;
            page_in   = page_ff + 8'd1;
         end else begin
            offset_in = offset_next[OFFS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= POS_LENGTH;
         length_ff   <= 8'd0;
         left_ff     <= 8'd0;
         rec_kind_ff <= 8'd0;
         sum_ff      <= 8'd0;
         low_ff      <= 8'd0;
         have_low_ff <= 1'b0;
         offset_ff   <= '0;
         page_ff     <= 8'd0;
         ended_ff    <= 1'b0;
      end else if (step) begin
         pos_ff      <= pos_in;
         length_ff   <= length_in;
         left_ff     <= left_in;
         rec_kind_ff <= rec_kind_in;
         sum_ff      <= sum_in;
         low_ff      <= low_in;
         have_low_ff <= have_low_in;
         offset_ff   <= offset_in;
         page_ff     <= page_in;
         ended_ff    <= ended_in;
      end
   end

endmodule

// File: hdl/hrc_out_reg.sv
// Result register that holds one word until the receiver takes it.
module hrc_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  hrc_pkg::result_type load_res,
   input  logic                rsp_stall,
   output logic                full,
   output logic                free,
   output hrc_pkg::result_type out_res
);

   logic                valid_ff, valid_in;
   hrc_pkg::result_type data_ff;

   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = load ? 1'b1 : (free ? 1'b0 : valid_ff);
   assign full     = valid_ff;

   always_comb begin
      out_res       = data_ff;
      out_res.valid = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_res;
      end
   end

endmodule

// File: hdl/hex_record_checker_word_packer.sv
// Top level: input byte register, record processing and result register.
// Binary hex record checker and flash word packer.
// The req_ channel carries one record byte per word (length, address high,
// address low, type, data bytes, checksum). The rsp_ channel returns at most
// one word per byte: a packed 16-bit data word with its page offset and page
// number, a checksum good or bad report, or an end-of-file report.
// A byte is taken when req_valid is high and req_stall is low; a result is
// taken when rsp_valid is high and rsp_stall is low.
// Throughput is one byte per cycle while the receiver keeps up. A byte lands
// in the input register at its accept edge and is processed when it moves on
// from there, which waits while the output register is full and stalled. Its
// result is then registered in the output register and shown on rsp_.
// A byte only stalls when the input register still holds a byte while the
// output register is full and held by rsp_stall.
// Reset clears the field sequencer, checksum, page offset and page number, so
// the stream restarts with a length byte on page 0. After an end-of-file
// record all further bytes are taken and dropped until reset.
module hex_record_checker_word_packer #(
   parameter int PAGE_BYTES = hrc_pkg::PAGE_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_record_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_flash_word,
   output logic [6:0]  rsp_byte_offset,
   output logic [7:0]  rsp_page_number,
   output logic        rsp_page_done
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                req_take;
   logic                advance;
   logic                out_full;
   logic                out_free;
   hrc_pkg::result_type core_res;
   hrc_pkg::result_type out_res;

   // move the held byte on whenever the result register can take its result
   assign advance     = in_valid_ff && out_free;
   assign req_stall   = in_valid_ff && !out_free;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_record_byte;
      end
   end

   hrc_core #(
      .PAGE_BYTES(PAGE_BYTES)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .rec_byte (in_byte_ff),
      .res      (core_res)
   );

   hrc_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && core_res.valid),
      .load_res  (core_res),
      .rsp_stall (rsp_stall),
      .full      (out_full),
      .free      (out_free),
      .out_res   (out_res)
   );

   assign rsp_valid       = out_full;
   assign rsp_kind        = out_res.kind;
   assign rsp_flash_word  = out_res.flash_word;
   assign rsp_byte_offset = out_res.byte_offset;
   assign rsp_page_number = out_res.page_number;
   assign rsp_page_done   = out_res.page_done;

   a_stall_needs_byte: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid && rsp_stall))
      else $error("input stalled without a held byte behind a stalled result");

   a_eof_commits: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == hrc_pkg::KIND_EOF) |-> rsp_page_done)
      else $error("end of file reported without page commit");

   a_report_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == hrc_pkg::KIND_GOOD || rsp_kind == hrc_pkg::KIND_BAD))
      |-> (!rsp_page_done && rsp_flash_word == 16'd0))
      else $error("checksum report carries data or page commit");

   a_advance_drains: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !req_stall && !req_valid) |=> !in_valid_ff)
      else $error("held byte not consumed");

endmodule
